[hw/rtl/rti_pkg.sv]
// rti_pkg: shared widths, codes and structs of the ray/triangle intersection unit
// used by rti_front, rti_queue, rti_back and ray_triangle_intersect_unit
package rti_pkg;

   localparam int CoordW    = 16;
   localparam int DiffW     = CoordW + 1;
   localparam int NormW     = 2 * DiffW + 1;
   localparam int ProdW     = NormW + DiffW;
   localparam int DotW      = ProdW + 2;
   localparam int GramW     = 2 * DiffW + 2;
   localparam int BaryW     = 2 * GramW + 2;
   localparam int RayFrac   = 16;
   localparam int RayIntCap = 24;
   localparam int QuotW     = RayIntCap + RayFrac;
   localparam int RemW      = DotW + 1;
   localparam int OffW      = QuotW + DiffW + 1 - RayFrac;
   localparam int HitW      = OffW + 2;
   localparam int LimitW    = 32;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [LimitW-1:0] LimitReset = LimitW'(1);

   localparam logic FnLoad = 1'b0;
   localparam logic FnTest = 1'b1;

   typedef logic signed [CoordW-1:0] coord_type;
   typedef logic signed [DiffW-1:0]  diff_type;
   typedef logic signed [GramW-1:0]  gram_type;

   typedef enum logic [1:0] {
      ST_DEGENERATE = 2'd0,
      ST_DISJOINT   = 2'd1,
      ST_HIT        = 2'd2,
      ST_PLANE      = 2'd3
   } status_type;

   // one triangle test with the ray it runs against
   typedef struct packed {
      coord_type [2:0] p0;
      coord_type [2:0] org;
      diff_type  [2:0] u;
      diff_type  [2:0] v;
      diff_type  [2:0] w0;
      diff_type  [2:0] dir;
   } job_type;

   typedef struct packed {
      status_type      status;
      logic            early;
      coord_type [2:0] p0;
      coord_type [2:0] org;
      diff_type  [2:0] u;
      diff_type  [2:0] v;
      diff_type  [2:0] dir;
      gram_type        uu;
      gram_type        uv;
      gram_type        vv;
   } tail_type;

   typedef struct packed {
      tail_type          tl;
      logic              clamp;
      logic [DotW-1:0]   ma;
      logic [DotW-1:0]   mb;
      logic [DotW-1:0]   rem;
      logic [QuotW-1:0]  quo;
   } div_type;

   typedef struct packed {
      status_type      status;
      logic            early;
      coord_type [2:0] hp;
   } fin_type;

endpackage

[hw/rtl/rti_queue.sv]
// rti_queue: short job queue between the front and back parts
// depends on rti_pkg
module rti_queue #(
   parameter int DEPTH = rti_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rti_pkg::job_type  push_job,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output rti_pkg::job_type  head_job
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   rti_pkg::job_type mem_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   assign full      = (count_ff == CntW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_job  = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

[hw/rtl/rti_front.sv]
// rti_front: accepts request words, keeps the ray and forms triangle jobs
// depends on rti_pkg
module rti_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_func,
   input  rti_pkg::coord_type req_first_x,
   input  rti_pkg::coord_type req_first_y,
   input  rti_pkg::coord_type req_first_z,
   input  rti_pkg::coord_type req_second_x,
   input  rti_pkg::coord_type req_second_y,
   input  rti_pkg::coord_type req_second_z,
   input  rti_pkg::coord_type req_third_x,
   input  rti_pkg::coord_type req_third_y,
   input  rti_pkg::coord_type req_third_z,
   input  logic               q_full,
   output logic               q_push,
   output rti_pkg::job_type   q_job
);

   rti_pkg::coord_type org_ff [3];
   rti_pkg::coord_type org_in [3];
   rti_pkg::diff_type  dir_ff [3];
   rti_pkg::diff_type  dir_in [3];
   rti_pkg::coord_type first  [3];
   rti_pkg::coord_type second [3];
   rti_pkg::coord_type third  [3];
   logic               accept;
   logic               load;

   assign first[0]  = req_first_x;
   assign first[1]  = req_first_y;
   assign first[2]  = req_first_z;
   assign second[0] = req_second_x;
   assign second[1] = req_second_y;
   assign second[2] = req_second_z;
   assign third[0]  = req_third_x;
   assign third[1]  = req_third_y;
   assign third[2]  = req_third_z;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign load      = accept && (req_func == rti_pkg::FnLoad);
   assign q_push    = accept && (req_func == rti_pkg::FnTest);

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         org_in[k] = org_ff[k];
         dir_in[k] = dir_ff[k];
         if (load) begin
            org_in[k] = first[k];
            dir_in[k] = rti_pkg::DiffW'(second[k]) - rti_pkg::DiffW'(first[k]);
         end
         q_job.p0[k]  = first[k];
         q_job.org[k] = org_ff[k];
         q_job.dir[k] = dir_ff[k];
         q_job.u[k]   = rti_pkg::DiffW'(second[k]) - rti_pkg::DiffW'(first[k]);
         q_job.v[k]   = rti_pkg::DiffW'(third[k]) - rti_pkg::DiffW'(first[k]);
         q_job.w0[k]  = rti_pkg::DiffW'(org_ff[k]) - rti_pkg::DiffW'(first[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            org_ff[k] <= '0;
            dir_ff[k] <= '0;
         end
      end else begin
         for (int k = 0; k < 3; k++) begin
            org_ff[k] <= org_in[k];
            dir_ff[k] <= dir_in[k];
         end
      end
   end

endmodule

[hw/rtl/rti_back.sv]
// rti_back: arithmetic pipeline (normal, plane distance, ray parameter divider,
// hit point, inside test) and the result register; depends on rti_pkg
module rti_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              job_valid,
   input  rti_pkg::job_type                  job,
   output logic                              job_pop,
   input  logic                              csr_write,
   input  logic [rti_pkg::LimitW-1:0]        csr_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_status,
   output rti_pkg::coord_type                rsp_hit_x,
   output rti_pkg::coord_type                rsp_hit_y,
   output rti_pkg::coord_type                rsp_hit_z
);

   localparam int NormW  = rti_pkg::NormW;
   localparam int ProdW  = rti_pkg::ProdW;
   localparam int DotW   = rti_pkg::DotW;
   localparam int GramW  = rti_pkg::GramW;
   localparam int BaryW  = rti_pkg::BaryW;
   localparam int QuotW  = rti_pkg::QuotW;
   localparam int RemW   = rti_pkg::RemW;
   localparam int OffW   = rti_pkg::OffW;
   localparam int HitW   = rti_pkg::HitW;
   localparam int DiffW  = rti_pkg::DiffW;
   localparam int CoordW = rti_pkg::CoordW;
   localparam int RayFrac   = rti_pkg::RayFrac;
   localparam int RayIntCap = rti_pkg::RayIntCap;

   logic adv;
   logic [rti_pkg::LimitW-1:0] limit_ff;

   // stage 1: normal and gram terms
   logic                     s1_valid_ff;
   rti_pkg::job_type         s1_job_ff;
   logic signed [NormW-1:0]  s1_n_ff [3];
   logic signed [NormW-1:0]  s1_n_in [3];
   rti_pkg::gram_type        s1_uu_ff, s1_uv_ff, s1_vv_ff;
   rti_pkg::gram_type        s1_uu_in, s1_uv_in, s1_vv_in;

   // stage 2: products for plane distance and slope
   logic                     s2_valid_ff;
   rti_pkg::job_type         s2_job_ff;
   logic signed [ProdW-1:0]  s2_pn_ff [3];
   logic signed [ProdW-1:0]  s2_pd_ff [3];
   logic signed [ProdW-1:0]  s2_pn_in [3];
   logic signed [ProdW-1:0]  s2_pd_in [3];
   logic                     s2_degen_ff, s2_degen_in;
   rti_pkg::gram_type        s2_uu_ff, s2_uv_ff, s2_vv_ff;

   // stage 3: sums
   logic                     s3_valid_ff;
   rti_pkg::job_type         s3_job_ff;
   logic signed [DotW-1:0]   s3_a_ff, s3_a_in;
   logic signed [DotW-1:0]   s3_b_ff, s3_b_in;
   logic                     s3_degen_ff;
   rti_pkg::gram_type        s3_uu_ff, s3_uv_ff, s3_vv_ff;

   // divider stages
   logic                     dv_ff  [QuotW+1];
   rti_pkg::div_type         div_ff [QuotW+1];
   rti_pkg::div_type         div_in [1:QuotW];
   rti_pkg::div_type         div0_in;

   // stage m: ray offsets
   logic                     m_valid_ff;
   rti_pkg::tail_type        m_tl_ff;
   logic [OffW-1:0]          m_off_ff [3];
   logic [OffW-1:0]          m_off_in [3];

   // stage h: hit point
   logic                     h_valid_ff;
   rti_pkg::tail_type        h_tl_ff, h_tl_in;
   rti_pkg::coord_type       h_hp_ff [3];
   rti_pkg::coord_type       h_hp_in [3];
   rti_pkg::diff_type        h_w_ff  [3];
   rti_pkg::diff_type        h_w_in  [3];

   // stage d1..d3: inside test
   logic                     d1_valid_ff;
   rti_pkg::fin_type         d1_fin_ff;
   rti_pkg::gram_type        d1_uu_ff, d1_uv_ff, d1_vv_ff;
   rti_pkg::gram_type        d1_wu_ff, d1_wv_ff, d1_wu_in, d1_wv_in;

   logic                     d2_valid_ff;
   rti_pkg::fin_type         d2_fin_ff;
   logic signed [BaryW-1:0]  d2_uvuv_ff, d2_uuvv_ff, d2_uvwv_ff;
   logic signed [BaryW-1:0]  d2_vvwu_ff, d2_uvwu_ff, d2_uuwv_ff;

   logic                     d3_valid_ff;
   rti_pkg::fin_type         d3_fin_ff;
   logic signed [BaryW-1:0]  d3_dd_ff, d3_ns_ff, d3_nt_ff;

   // result register
   logic                     rsp_valid_ff;
   rti_pkg::status_type      rsp_status_ff, rsp_status_in;
   rti_pkg::coord_type       rsp_hit_ff [3];
   rti_pkg::coord_type       rsp_hit_in [3];

   assign adv     = !rsp_valid_ff || !rsp_stall;
   assign job_pop = adv && job_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= rti_pkg::LimitReset;
      end else if (csr_write) begin
         limit_ff <= csr_data;
      end
   end

   always_comb begin
      s1_n_in[0] = NormW'($signed(job.u[1]) * $signed(job.v[2]))
                 - NormW'($signed(job.u[2]) * $signed(job.v[1]));
      s1_n_in[1] = NormW'($signed(job.u[2]) * $signed(job.v[0]))
                 - NormW'($signed(job.u[0]) * $signed(job.v[2]));
      s1_n_in[2] = NormW'($signed(job.u[0]) * $signed(job.v[1]))
                 - NormW'($signed(job.u[1]) * $signed(job.v[0]));
      s1_uu_in = '0;
      s1_uv_in = '0;
      s1_vv_in = '0;
      for (int k = 0; k < 3; k++) begin
         s1_uu_in = s1_uu_in + GramW'($signed(job.u[k]) * $signed(job.u[k]));
         s1_uv_in = s1_uv_in + GramW'($signed(job.u[k]) * $signed(job.v[k]));
         s1_vv_in = s1_vv_in + GramW'($signed(job.v[k]) * $signed(job.v[k]));
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         s2_pn_in[k] = ProdW'(s1_n_ff[k] * $signed(s1_job_ff.w0[k]));
         s2_pd_in[k] = ProdW'(s1_n_ff[k] * $signed(s1_job_ff.dir[k]));
      end
      s2_degen_in = (s1_n_ff[0] == '0) && (s1_n_ff[1] == '0) && (s1_n_ff[2] == '0);
   end

   always_comb begin
      s3_a_in = -(DotW'(s2_pn_ff[0]) + DotW'(s2_pn_ff[1]) + DotW'(s2_pn_ff[2]));
      s3_b_in = DotW'(s2_pd_ff[0]) + DotW'(s2_pd_ff[1]) + DotW'(s2_pd_ff[2]);
   end

   // classification and divider setup
   always_comb begin
      logic [DotW-1:0] ma;
      logic [DotW-1:0] mb;
      logic            parallel;
      logic            away;
      ma = s3_a_ff[DotW-1] ? DotW'(-s3_a_ff) : DotW'(s3_a_ff);
      mb = s3_b_ff[DotW-1] ? DotW'(-s3_b_ff) : DotW'(s3_b_ff);
      parallel = (s3_b_ff == '0) || (mb < DotW'(limit_ff));
      away = (s3_a_ff != '0) && (s3_a_ff[DotW-1] != s3_b_ff[DotW-1]);
      div0_in.tl.p0  = s3_job_ff.p0;
      div0_in.tl.org = s3_job_ff.org;
      div0_in.tl.u   = s3_job_ff.u;
      div0_in.tl.v   = s3_job_ff.v;
      div0_in.tl.dir = s3_job_ff.dir;
      div0_in.tl.uu  = s3_uu_ff;
      div0_in.tl.uv  = s3_uv_ff;
      div0_in.tl.vv  = s3_vv_ff;
      if (s3_degen_ff) begin
         div0_in.tl.status = rti_pkg::ST_DEGENERATE;
         div0_in.tl.early  = 1'b1;
      end else if (parallel) begin
         div0_in.tl.status = (s3_a_ff == '0) ? rti_pkg::ST_PLANE : rti_pkg::ST_DISJOINT;
         div0_in.tl.early  = 1'b1;
      end else if (away) begin
         div0_in.tl.status = rti_pkg::ST_DISJOINT;
         div0_in.tl.early  = 1'b1;
      end else begin
         div0_in.tl.status = rti_pkg::ST_HIT;
         div0_in.tl.early  = 1'b0;
      end
      div0_in.clamp = {{RayIntCap{1'b0}}, ma} >= {mb, {RayIntCap{1'b0}}};
      div0_in.ma    = ma;
      div0_in.mb    = mb;
      div0_in.rem   = DotW'(ma >> RayIntCap);
      div0_in.quo   = '0;
   end

   // restoring divider, one quotient bit per stage
   always_comb begin
      logic [RemW-1:0]          trial;
      logic [DotW+RayFrac-1:0]  num;
      for (int k = 0; k < QuotW; k++) begin
         div_in[k+1] = div_ff[k];
         num   = {div_ff[k].ma, {RayFrac{1'b0}}};
         trial = {div_ff[k].rem, num[QuotW-1-k]};
         if (trial >= {1'b0, div_ff[k].mb}) begin
            div_in[k+1].rem = DotW'(trial - {1'b0, div_ff[k].mb});
            div_in[k+1].quo[QuotW-1-k] = 1'b1;
         end else begin
            div_in[k+1].rem = DotW'(trial);
         end
      end
   end

   always_comb begin
      logic [QuotW:0]          rq;
      logic [DiffW-1:0]        dmag;
      logic [QuotW+DiffW:0]    prod;
      rq = div_ff[QuotW].clamp ? {1'b1, {QuotW{1'b0}}} : {1'b0, div_ff[QuotW].quo};
      for (int k = 0; k < 3; k++) begin
         dmag = div_ff[QuotW].tl.dir[k][DiffW-1] ? DiffW'(-$signed(div_ff[QuotW].tl.dir[k]))
                                                  : DiffW'(div_ff[QuotW].tl.dir[k]);
         prod = rq * dmag;
         m_off_in[k] = prod[QuotW+DiffW:RayFrac];
      end
   end

   always_comb begin
      logic signed [HitW-1:0] hp;
      logic signed [HitW-1:0] org_s;
      logic signed [HitW-1:0] off_s;
      logic                   oob;
      h_tl_in = m_tl_ff;
      oob = 1'b0;
      for (int k = 0; k < 3; k++) begin
         org_s = HitW'($signed(m_tl_ff.org[k]));
         off_s = $signed({2'b00, m_off_ff[k]});
         hp = m_tl_ff.dir[k][DiffW-1] ? org_s - off_s : org_s + off_s;
         if (hp != HitW'($signed(hp[CoordW-1:0]))) begin
            oob = 1'b1;
         end
         h_hp_in[k] = hp[CoordW-1:0];
         h_w_in[k]  = DiffW'($signed(hp[CoordW-1:0])) - DiffW'($signed(m_tl_ff.p0[k]));
      end
      if (!m_tl_ff.early && oob) begin
         h_tl_in.status = rti_pkg::ST_DISJOINT;
         h_tl_in.early  = 1'b1;
      end
   end

   always_comb begin
      d1_wu_in = '0;
      d1_wv_in = '0;
      for (int k = 0; k < 3; k++) begin
         d1_wu_in = d1_wu_in + GramW'($signed(h_w_ff[k]) * $signed(h_tl_ff.u[k]));
         d1_wv_in = d1_wv_in + GramW'($signed(h_w_ff[k]) * $signed(h_tl_ff.v[k]));
      end
   end

   always_comb begin
      logic fail;
      fail = (d3_ns_ff > 0) || (d3_ns_ff < d3_dd_ff) || (d3_nt_ff > 0)
          || ((d3_ns_ff + d3_nt_ff) < d3_dd_ff);
      if (d3_fin_ff.early) begin
         rsp_status_in = d3_fin_ff.status;
      end else if (fail) begin
         rsp_status_in = rti_pkg::ST_DISJOINT;
      end else begin
         rsp_status_in = rti_pkg::ST_HIT;
      end
      for (int k = 0; k < 3; k++) begin
         rsp_hit_in[k] = (rsp_status_in == rti_pkg::ST_HIT) ? d3_fin_ff.hp[k] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         for (int k = 0; k <= QuotW; k++) begin
            dv_ff[k] <= 1'b0;
         end
         m_valid_ff   <= 1'b0;
         h_valid_ff   <= 1'b0;
         d1_valid_ff  <= 1'b0;
         d2_valid_ff  <= 1'b0;
         d3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= job_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         dv_ff[0]     <= s3_valid_ff;
         for (int k = 0; k < QuotW; k++) begin
            dv_ff[k+1] <= dv_ff[k];
         end
         m_valid_ff   <= dv_ff[QuotW];
         h_valid_ff   <= m_valid_ff;
         d1_valid_ff  <= h_valid_ff;
         d2_valid_ff  <= d1_valid_ff;
         d3_valid_ff  <= d2_valid_ff;
         rsp_valid_ff <= d3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_job_ff <= job;
         s1_uu_ff  <= s1_uu_in;
         s1_uv_ff  <= s1_uv_in;
         s1_vv_ff  <= s1_vv_in;
         for (int k = 0; k < 3; k++) begin
            s1_n_ff[k]  <= s1_n_in[k];
            s2_pn_ff[k] <= s2_pn_in[k];
            s2_pd_ff[k] <= s2_pd_in[k];
            m_off_ff[k] <= m_off_in[k];
            h_hp_ff[k]  <= h_hp_in[k];
            h_w_ff[k]   <= h_w_in[k];
            rsp_hit_ff[k] <= rsp_hit_in[k];
         end
         s2_job_ff   <= s1_job_ff;
         s2_degen_ff <= s2_degen_in;
         s2_uu_ff    <= s1_uu_ff;
         s2_uv_ff    <= s1_uv_ff;
         s2_vv_ff    <= s1_vv_ff;
         s3_job_ff   <= s2_job_ff;
         s3_a_ff     <= s3_a_in;
         s3_b_ff     <= s3_b_in;
         s3_degen_ff <= s2_degen_ff;
         s3_uu_ff    <= s2_uu_ff;
         s3_uv_ff    <= s2_uv_ff;
         s3_vv_ff    <= s2_vv_ff;
         div_ff[0]   <= div0_in;
         for (int k = 1; k <= QuotW; k++) begin
            div_ff[k] <= div_in[k];
         end
         m_tl_ff <= div_ff[QuotW].tl;
         h_tl_ff <= h_tl_in;
         d1_fin_ff.status <= h_tl_ff.status;
         d1_fin_ff.early  <= h_tl_ff.early;
         d1_fin_ff.hp[0]  <= h_hp_ff[0];
         d1_fin_ff.hp[1]  <= h_hp_ff[1];
         d1_fin_ff.hp[2]  <= h_hp_ff[2];
         d1_uu_ff   <= h_tl_ff.uu;
         d1_uv_ff   <= h_tl_ff.uv;
         d1_vv_ff   <= h_tl_ff.vv;
         d1_wu_ff   <= d1_wu_in;
         d1_wv_ff   <= d1_wv_in;
         d2_fin_ff  <= d1_fin_ff;
         d2_uvuv_ff <= BaryW'(d1_uv_ff * d1_uv_ff);
         d2_uuvv_ff <= BaryW'(d1_uu_ff * d1_vv_ff);
         d2_uvwv_ff <= BaryW'(d1_uv_ff * d1_wv_ff);
         d2_vvwu_ff <= BaryW'(d1_vv_ff * d1_wu_ff);
         d2_uvwu_ff <= BaryW'(d1_uv_ff * d1_wu_ff);
         d2_uuwv_ff <= BaryW'(d1_uu_ff * d1_wv_ff);
         d3_fin_ff  <= d2_fin_ff;
         d3_dd_ff   <= d2_uvuv_ff - d2_uuvv_ff;
         d3_ns_ff   <= d2_uvwv_ff - d2_vvwu_ff;
         d3_nt_ff   <= d2_uvwu_ff - d2_uuwv_ff;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_hit_x  = rsp_hit_ff[0];
   assign rsp_hit_y  = rsp_hit_ff[1];
   assign rsp_hit_z  = rsp_hit_ff[2];

endmodule

[hw/rtl/ray_triangle_intersect_unit.sv]
// a test word passes the queue, s1..s3, the 40-stage ray parameter divider, m, h,
// d1..d3 and the result register; a load word takes effect for test words accepted
// from the next cycle on and gives no result; one word per cycle while not stalled
// reset: synchronous; clears the ray to zero, the parallel limit to one, the queue
// and all pipeline valids; words are taken from the first cycle after reset
module ray_triangle_intersect_unit #(
   parameter int QUEUE_DEPTH = rti_pkg::QUEUE_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_func,
   input  logic signed [15:0]            req_first_x,
   input  logic signed [15:0]            req_first_y,
   input  logic signed [15:0]            req_first_z,
   input  logic signed [15:0]            req_second_x,
   input  logic signed [15:0]            req_second_y,
   input  logic signed [15:0]            req_second_z,
   input  logic signed [15:0]            req_third_x,
   input  logic signed [15:0]            req_third_y,
   input  logic signed [15:0]            req_third_z,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_status,
   output logic signed [15:0]            rsp_hit_x,
   output logic signed [15:0]            rsp_hit_y,
   output logic signed [15:0]            rsp_hit_z,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [31:0]                   csr_data
);

   rti_pkg::job_type push_job;
   rti_pkg::job_type head_job;
   logic             q_push;
   logic             q_full;
   logic             q_pop;
   logic             q_not_empty;

   assign csr_ready = 1'b1;

   rti_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_func     (req_func),
      .req_first_x  (req_first_x),
      .req_first_y  (req_first_y),
      .req_first_z  (req_first_z),
      .req_second_x (req_second_x),
      .req_second_y (req_second_y),
      .req_second_z (req_second_z),
      .req_third_x  (req_third_x),
      .req_third_y  (req_third_y),
      .req_third_z  (req_third_z),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_job        (push_job)
   );

   rti_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_job  (push_job),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_job  (head_job)
   );

   rti_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (q_not_empty),
      .job        (head_job),
      .job_pop    (q_pop),
      .csr_write  (csr_valid && csr_ready),
      .csr_data   (csr_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_status (rsp_status),
      .rsp_hit_x  (rsp_hit_x),
      .rsp_hit_y  (rsp_hit_y),
      .rsp_hit_z  (rsp_hit_z)
   );

endmodule

[hw/rtl/rti_checker.sv]
// rti_checker: port-level properties of ray_triangle_intersect_unit, bound to it
// depends on rti_pkg
module rti_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [1:0]         rsp_status,
   input logic signed [15:0] rsp_hit_x,
   input logic signed [15:0] rsp_hit_y,
   input logic signed [15:0] rsp_hit_z,
   input logic               csr_ready
);

   // result word holds while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_hit_x) && $stable(rsp_hit_y) && $stable(rsp_hit_z))
      else $error("result word changed while stalled");

   // hit point is zero unless hit
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != rti_pkg::ST_HIT) |->
         (rsp_hit_x == '0) && (rsp_hit_y == '0) && (rsp_hit_z == '0))
      else $error("nonzero hit point on a miss");

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word right after reset");

   // register port never refuses a write
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      $fell(csr_ready) |-> 1'b0)
      else $error("register port dropped ready");

   // requests stall only while a result word waits
   a_stall_backed: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |-> rsp_valid)
      else $error("request stalled with no result word waiting");

endmodule

bind ray_triangle_intersect_unit rti_checker u_rti_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_status (rsp_status),
   .rsp_hit_x  (rsp_hit_x),
   .rsp_hit_y  (rsp_hit_y),
   .rsp_hit_z  (rsp_hit_z),
   .csr_ready  (csr_ready)
);

[tb/ray_triangle_intersect_unit_test.sv]
// ray_triangle_intersect_unit_test: self-checking testbench of the ray/triangle unit
// drives ray loads and triangle tests under random gaps and stalls, predicts each result
// word in a local model and checks it; depends on rti_pkg and ray_triangle_intersect_unit
module ray_triangle_intersect_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SettleCycles = 60;
   localparam int CycleLimit   = 400000;

   typedef struct packed {
      logic                     func;
      rti_pkg::coord_type [8:0] c;
   } ray_word_type;

   typedef struct packed {
      rti_pkg::status_type      st;
      rti_pkg::coord_type [2:0] hp;
   } hit_word_type;

   typedef logic signed [127:0] wide_type;

   logic clock;
   logic reset;
   logic req_valid, req_stall, req_func;
   rti_pkg::coord_type req_c [9];
   logic rsp_valid, rsp_stall;
   logic [1:0] rsp_status;
   rti_pkg::coord_type rsp_hit_x, rsp_hit_y, rsp_hit_z;
   logic csr_valid, csr_ready;
   logic [31:0] csr_data;

   ray_word_type pending_words[$];
   hit_word_type expected_hits[$];

   longint ray_org [3];
   longint ray_dir [3];
   logic [31:0] limit_copy;
   int csr_writes;
   int errors, results_seen, cycles;
   int status_seen [4];
   int gap_left, burst_left;
   bit req_held;

   ray_triangle_intersect_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_func    (req_func),
      .req_first_x (req_c[0]),
      .req_first_y (req_c[1]),
      .req_first_z (req_c[2]),
      .req_second_x(req_c[3]),
      .req_second_y(req_c[4]),
      .req_second_z(req_c[5]),
      .req_third_x (req_c[6]),
      .req_third_y (req_c[7]),
      .req_third_z (req_c[8]),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_status  (rsp_status),
      .rsp_hit_x   (rsp_hit_x),
      .rsp_hit_y   (rsp_hit_y),
      .rsp_hit_z   (rsp_hit_z),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic longint unsigned magnitude(longint x);
      return longint'(x < 0 ? -x : x);
   endfunction

   // returns 1 when the word gives a result; a load only updates the ray
   function automatic bit predict(input ray_word_type w, output hit_word_type r);
      longint p0 [3], p1 [3], p2 [3], u [3], v [3], n [3], w0 [3], wd [3], hp [3];
      longint a, b, uu, uv, vv, wu, wv;
      longint unsigned ma, mb, q, rem, rq, off;
      wide_type dd, ns, nt;
      r = '0;
      r.st = rti_pkg::ST_DISJOINT;
      for (int k = 0; k < 3; k++) begin
         p0[k] = w.c[k];
         p1[k] = w.c[3 + k];
         p2[k] = w.c[6 + k];
      end
      if (w.func == rti_pkg::FnLoad) begin
         for (int k = 0; k < 3; k++) begin
            ray_org[k] = p0[k];
            ray_dir[k] = p1[k] - p0[k];
         end
         return 1'b0;
      end
      for (int k = 0; k < 3; k++) begin
         u[k] = p1[k] - p0[k];
         v[k] = p2[k] - p0[k];
         w0[k] = ray_org[k] - p0[k];
      end
      n[0] = u[1] * v[2] - u[2] * v[1];
      n[1] = u[2] * v[0] - u[0] * v[2];
      n[2] = u[0] * v[1] - u[1] * v[0];
      if (n[0] == 0 && n[1] == 0 && n[2] == 0) begin
         r.st = rti_pkg::ST_DEGENERATE;
         return 1'b1;
      end
      a = -(n[0] * w0[0] + n[1] * w0[1] + n[2] * w0[2]);
      b = n[0] * ray_dir[0] + n[1] * ray_dir[1] + n[2] * ray_dir[2];
      mb = magnitude(b);
      if (b == 0 || mb < longint'(limit_copy)) begin
         r.st = (a == 0) ? rti_pkg::ST_PLANE : rti_pkg::ST_DISJOINT;
         return 1'b1;
      end
      if (a != 0 && ((a < 0) != (b < 0))) return 1'b1;
      ma = magnitude(a);
      q = ma / mb;
      rem = ma % mb;
      if (q >= (64'd1 << rti_pkg::RayIntCap)) begin
         rq = 64'd1 << (rti_pkg::RayIntCap + rti_pkg::RayFrac);
      end else begin
         rq = q;
         for (int k = 0; k < rti_pkg::RayFrac; k++) begin
            rem = rem << 1;
            rq = rq << 1;
            if (rem >= mb) begin
               rem = rem - mb;
               rq = rq | 64'd1;
            end
         end
      end
      for (int k = 0; k < 3; k++) begin
         off = (rq * magnitude(ray_dir[k])) >> rti_pkg::RayFrac;
         hp[k] = ray_org[k] + (ray_dir[k] < 0 ? -longint'(off) : longint'(off));
         if (hp[k] < -32768 || hp[k] > 32767) return 1'b1;
         wd[k] = hp[k] - p0[k];
      end
      uu = u[0] * u[0] + u[1] * u[1] + u[2] * u[2];
      uv = u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
      vv = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
      wu = wd[0] * u[0] + wd[1] * u[1] + wd[2] * u[2];
      wv = wd[0] * v[0] + wd[1] * v[1] + wd[2] * v[2];
      dd = wide_type'(uv) * wide_type'(uv) - wide_type'(uu) * wide_type'(vv);
      ns = wide_type'(uv) * wide_type'(wv) - wide_type'(vv) * wide_type'(wu);
      nt = wide_type'(uv) * wide_type'(wu) - wide_type'(uu) * wide_type'(wv);
      if (ns > 0 || ns < dd) return 1'b1;
      if (nt > 0 || ns + nt < dd) return 1'b1;
      r.st = rti_pkg::ST_HIT;
      for (int k = 0; k < 3; k++) r.hp[k] = rti_pkg::coord_type'(hp[k]);
      return 1'b1;
   endfunction

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
      errors++;
   endtask

   // acceptance, prediction, result check and register write tracking
   always @(posedge clock) begin
      hit_word_type h, e;
      cycles++;
      if (cycles > CycleLimit) begin
         $display("timeout after %0d cycles", cycles);
         $display("ray_triangle_intersect_unit regression: fail");
         $finish;
      end
      req_held = req_valid && req_stall;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            limit_copy = csr_data;
            csr_writes++;
         end
         if (req_valid && !req_stall) begin
            if (predict(pending_words[0], h)) expected_hits.push_back(h);
            void'(pending_words.pop_front());
         end
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            status_seen[rsp_status]++;
            if (expected_hits.size() == 0) begin
               report("unexpected word, status", rsp_status, -1);
            end else begin
               e = expected_hits.pop_front();
               if (rsp_status != e.st) report("status", rsp_status, e.st);
               if (rsp_hit_x != e.hp[0]) report("hit_x", rsp_hit_x, e.hp[0]);
               if (rsp_hit_y != e.hp[1]) report("hit_y", rsp_hit_y, e.hp[1]);
               if (rsp_hit_z != e.hp[2]) report("hit_z", rsp_hit_z, e.hp[2]);
            end
         end
      end
   end

   // sender in bursts with gaps, receiver stall pattern
   always @(negedge clock) begin
      int mode;
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         mode = (cycles / 97) % 4;
         case (mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 99) < 30);
            2: rsp_stall <= ($urandom_range(0, 99) < 80);
            default: rsp_stall <= cycles[0];
         endcase
         if (!req_held) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_words.size() != 0) begin
               req_valid <= 1'b1;
               req_func <= pending_words[0].func;
               for (int k = 0; k < 9; k++) req_c[k] <= pending_words[0].c[k];
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 99) < 40) ? $urandom_range(1, 8) : 0;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   function automatic rti_pkg::coord_type clip(longint x);
      if (x > 32767) return 16'sd32767;
      if (x < -32768) return -16'sd32768;
      return rti_pkg::coord_type'(x);
   endfunction

   function automatic longint spread(int m);
      return longint'($urandom_range(0, 2 * m)) - m;
   endfunction

   task automatic push_word(input logic f, input longint c0, c1, c2, c3, c4, c5,
                            input longint c6, c7, c8);
      ray_word_type w;
      w.func = f;
      w.c[0] = clip(c0); w.c[1] = clip(c1); w.c[2] = clip(c2);
      w.c[3] = clip(c3); w.c[4] = clip(c4); w.c[5] = clip(c5);
      w.c[6] = clip(c6); w.c[7] = clip(c7); w.c[8] = clip(c8);
      pending_words.push_back(w);
   endtask

   task automatic add_directed();
      push_word(rti_pkg::FnTest, 0, 0, 512, 256, 0, 512, 0, 256, 512);
      push_word(rti_pkg::FnLoad, 0, 0, 0, 0, 0, 256, 1111, -2222, 3333);
      push_word(rti_pkg::FnTest, -256, -256, 512, 256, -256, 512, 0, 256, 512);
      push_word(rti_pkg::FnTest, 0, 0, 512, 256, 256, 512, 512, 512, 512);
      push_word(rti_pkg::FnTest, 256, 0, 0, 256, 256, 0, 256, 0, 256);
      push_word(rti_pkg::FnTest, 0, 0, 0, 0, 256, 0, 0, 0, 256);
      push_word(rti_pkg::FnTest, -256, -256, -512, 256, -256, -512, 0, 256, -512);
      push_word(rti_pkg::FnTest, -256, -256, 0, 256, -256, 0, 0, 256, 0);
      push_word(rti_pkg::FnTest, 1000, 1000, 512, 1512, 1000, 512, 1000, 1512, 512);
      push_word(rti_pkg::FnTest, -256, -256, 512, 256, -256, 512, 0, 256, 513);
      push_word(rti_pkg::FnLoad, 5, 7, -3, 6, 7, -3, 0, 0, 0);
      push_word(rti_pkg::FnTest, -256, -256, 30000, 256, -256, 30000, 0, 256, 30000);
      push_word(rti_pkg::FnTest, -4000, -8000, 1, 4000, -8000, 3, 4000, 8000, -1);
      push_word(rti_pkg::FnLoad, -32768, -32768, -32768, 32767, 32767, 32767,
                -32768, 32767, -1);
      push_word(rti_pkg::FnTest, -32768, 32767, 0, 32767, -32768, 0, 32767, 32767, -32768);
      push_word(rti_pkg::FnTest, 32767, 32767, 32767, -32768, -32768, -32768, 0, 0, 0);
      push_word(rti_pkg::FnTest, -32768, -32768, 32767, 32767, -32768, -32768,
                -32768, 32767, -32768);
      push_word(rti_pkg::FnTest, 32767, 32767, 32767, 32767, 32767, 32767,
                32767, 32767, 32767);
      push_word(rti_pkg::FnLoad, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      push_word(rti_pkg::FnTest, -256, -256, 512, 256, -256, 512, 0, 256, 512);
   endtask

   // mostly aimed triangles around a point on the current ray, some noise
   task automatic add_random(input int count);
      longint o [3], d [3], p [3], s;
      int pick;
      o = '{0, 0, 0};
      d = '{0, 0, 256};
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            for (int k = 0; k < 3; k++) begin
               o[k] = spread(4096);
               d[k] = spread(($urandom_range(0, 3) == 0) ? 8 : 1024);
            end
            push_word(rti_pkg::FnLoad, o[0], o[1], o[2], o[0] + d[0], o[1] + d[1],
                      o[2] + d[2], spread(32768), spread(32768), spread(32768));
         end else if (pick < 16) begin
            push_word(logic'($urandom_range(0, 1)), spread(32768), spread(32768),
                      spread(32768), spread(32768), spread(32768), spread(32768),
                      spread(32768), spread(32768), spread(32768));
            if ($urandom_range(0, 1) == 0) begin
               o = '{0, 0, 0};
               d = '{0, 0, 0};
            end
         end else begin
            s = $urandom_range(4, 2048);
            for (int k = 0; k < 3; k++)
               p[k] = o[k] + d[k] * longint'($urandom_range(0, 12)) / 4
                    + spread(int'(s / 4));
            push_word(rti_pkg::FnTest, p[0] - s + spread(int'(s / 8)), p[1] - s,
                      p[2] + spread(int'(s)),
                      p[0] + s, p[1] - s + spread(int'(s / 8)), p[2] + spread(int'(s)),
                      p[0] + spread(int'(s / 2)), p[1] + s, p[2] + spread(int'(s)));
         end
      end
   endtask

   task automatic wait_idle();
      while (pending_words.size() != 0 || req_valid || expected_hits.size() != 0)
         @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   task automatic write_limit(input logic [31:0] value);
      int seen;
      seen = csr_writes;
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      while (csr_writes == seen) @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [31:0] limits [5];
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_func <= rti_pkg::FnLoad;
      for (int k = 0; k < 9; k++) req_c[k] <= '0;
      rsp_stall <= 1'b0;
      csr_valid <= 1'b0;
      csr_data <= '0;
      limit_copy = rti_pkg::LimitReset;
      for (int k = 0; k < 3; k++) begin
         ray_org[k] = 0;
         ray_dir[k] = 0;
      end
      limits[0] = rti_pkg::LimitReset;
      limits[1] = 32'd0;
      limits[2] = 32'hFFFF_FFFF;
      limits[3] = 32'd1 << $urandom_range(8, 30);
      limits[4] = $urandom;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      add_directed();
      wait_idle();
      for (int ph = 0; ph < 5; ph++) begin
         write_limit(limits[ph]);
         add_random(ph == 2 ? 80 : 180);
         wait_idle();
      end
      write_limit(rti_pkg::LimitReset);
      add_directed();
      wait_idle();
      $display("checked %0d result words over 6 limit settings: degenerate %0d, disjoint %0d,",
               results_seen, status_seen[0], status_seen[1]);
      $display("hit %0d, in plane %0d; %0d mismatches", status_seen[2], status_seen[3], errors);
      if (errors == 0 && expected_hits.size() == 0) begin
         $display("ray_triangle_intersect_unit regression: pass");
      end else begin
         $display("ray_triangle_intersect_unit regression: fail");
      end
      $finish;
   end

endmodule

[sim.f]
hw/rtl/rti_pkg.sv
hw/rtl/rti_queue.sv
hw/rtl/rti_front.sv
hw/rtl/rti_back.sv
hw/rtl/ray_triangle_intersect_unit.sv
hw/rtl/rti_checker.sv
tb/ray_triangle_intersect_unit_test.sv
